### rtl/core/pinq_pkg.sv
`timescale 1ns / 1ps
// Package for the positional insert queue: request kinds, status codes and cell operations.
// No dependencies; used by pinq_cell, positional_insert_queue and pinq_checker.
package pinq_pkg;

    // Default sizes, handed down through the top-level parameters
    localparam int DEPTH_DEF      = 16;
    localparam int COMP_WIDTH_DEF = 16;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_POP    = 2'd2,
        KIND_SEARCH = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // What one cell does at the next edge
    typedef enum logic [1:0] {
        OP_HOLD       = 2'd0,
        OP_FROM_LEFT  = 2'd1,
        OP_FROM_RIGHT = 2'd2,
        OP_LOAD       = 2'd3
    } t_cell_op;

endpackage

### rtl/core/pinq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the queue chain: holds an (x, y) entry and a registered match flag.
// Depends on pinq_pkg for the cell operation type.
module pinq_cell import pinq_pkg::*; #(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic                  i_probe,
    input  logic                  i_live,
    input  logic [COMP_WIDTH-1:0] i_left_x,
    input  logic [COMP_WIDTH-1:0] i_left_y,
    input  logic [COMP_WIDTH-1:0] i_right_x,
    input  logic [COMP_WIDTH-1:0] i_right_y,
    input  logic [COMP_WIDTH-1:0] i_new_x,
    input  logic [COMP_WIDTH-1:0] i_new_y,
    output logic [COMP_WIDTH-1:0] o_x,
    output logic [COMP_WIDTH-1:0] o_y,
    output logic                  o_hit
);

    logic [COMP_WIDTH-1:0] r_x, n_x;
    logic [COMP_WIDTH-1:0] r_y, n_y;
    logic                  r_hit, n_hit;

    // Entry select: keep, take a neighbor's entry, or load the new word
    always_comb begin
        case (i_op)
            OP_HOLD: begin
                n_x = r_x;
                n_y = r_y;
            end
            OP_FROM_LEFT: begin
                n_x = i_left_x;
                n_y = i_left_y;
            end
            OP_FROM_RIGHT: begin
                n_x = i_right_x;
                n_y = i_right_y;
            end
            OP_LOAD: begin
                n_x = i_new_x;
                n_y = i_new_y;
            end
            default: begin
                n_x = r_x;
                n_y = r_y;
            end
        endcase
    end

    // Match against the search key, taken from the entry before update
    always_comb begin
        n_hit = r_hit;
        if (i_probe) begin
            n_hit = i_live && (r_x == i_new_x) && (r_y == i_new_y);
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_hit <= n_hit;
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_hit = r_hit;

endmodule

### rtl/core/positional_insert_queue.sv
`timescale 1ns / 1ps
// Top level of the positional insert queue: a chain of pinq_cell entries plus request control.
// Depends on pinq_pkg and pinq_cell.
//
//   channel   direction  handshake                 payload
//   request   in         i_in_valid / o_in_stall   i_kind, i_position, i_data_x, i_data_y
//   result    out        o_out_valid / i_out_stall o_status, o_found, o_out_x, o_out_y, o_count
//
// One request is accepted per cycle while o_in_stall is low; every cell shifts, loads or holds at the accept edge.
// A result is registered first in the middle stage, together with the per-cell match flags,
// then in the output register, which takes the OR of those flags as the found bit.
// Reset (synchronous, active low) empties the queue; entry contents are not cleared.
// A stalled result holds the output register; the request side stalls only when
// both the middle stage and the output register are full.
module positional_insert_queue import pinq_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int COMP_WIDTH = COMP_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_kind,
    input  logic [CNT_W-1:0]      i_position,
    input  logic [COMP_WIDTH-1:0] i_data_x,
    input  logic [COMP_WIDTH-1:0] i_data_y,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic                  o_found,
    output logic [COMP_WIDTH-1:0] o_out_x,
    output logic [COMP_WIDTH-1:0] o_out_y,
    output logic [CNT_W-1:0]      o_count
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_kind                 w_kind;
    logic                  w_accept;
    logic                  w_adv;
    logic [CNT_W-1:0]      w_at;
    logic                  w_ins_ok;
    logic                  w_pop_ok;
    t_status               w_status;

    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_s1_valid, n_s1_valid;
    t_status               r_s1_status;
    logic [COMP_WIDTH-1:0] r_s1_x, r_s1_y;
    logic [CNT_W-1:0]      r_s1_count;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status;
    logic                  r_out_found;
    logic [COMP_WIDTH-1:0] r_out_x, r_out_y;
    logic [CNT_W-1:0]      r_out_count;

    logic [COMP_WIDTH-1:0] w_cx [DEPTH];
    logic [COMP_WIDTH-1:0] w_cy [DEPTH];
    logic [DEPTH-1:0]      w_hit;

    // Handshake: middle stage moves when the output register is free or drains
    assign w_kind     = t_kind'(i_kind);
    assign w_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Request decode and status
    always_comb begin
        w_at     = (w_kind == KIND_PUSH) ? r_count : i_position;
        w_ins_ok = 1'b0;
        w_pop_ok = 1'b0;
        w_status = ST_OK;
        n_count  = r_count;
        case (w_kind)
            KIND_PUSH, KIND_INSERT: begin
                if (w_at > r_count) begin
                    w_status = ST_RANGE;
                end else if (r_count == FULL_CNT) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins_ok = 1'b1;
                end
            end
            KIND_POP: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_pop_ok = 1'b1;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
        if (w_accept && w_ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_accept && w_pop_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Cell chain: each cell decodes its move from its own index
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX  = CNT_W'(gi);
        localparam logic [CNT_W-1:0] NEXT = CNT_W'(gi + 1);

        t_cell_op              w_op;
        logic [COMP_WIDTH-1:0] w_lx, w_ly, w_rx, w_ry;

        always_comb begin
            w_op = OP_HOLD;
            if (w_accept && w_ins_ok) begin
                if (IDX == w_at) begin
                    w_op = OP_LOAD;
                end else if (IDX > w_at && IDX <= r_count) begin
                    w_op = OP_FROM_LEFT;
                end
            end else if (w_accept && w_pop_ok) begin
                if (NEXT < r_count) begin
                    w_op = OP_FROM_RIGHT;
                end
            end
        end

        if (gi == 0) begin : g_head
            assign w_lx = '0;
            assign w_ly = '0;
        end else begin : g_mid
            assign w_lx = w_cx[gi-1];
            assign w_ly = w_cy[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_rx = '0;
            assign w_ry = '0;
        end else begin : g_body
            assign w_rx = w_cx[gi+1];
            assign w_ry = w_cy[gi+1];
        end

        pinq_cell #(
            .COMP_WIDTH (COMP_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_op      (w_op),
            .i_probe   (w_accept),
            .i_live    ((w_kind == KIND_SEARCH) && (IDX < r_count)),
            .i_left_x  (w_lx),
            .i_left_y  (w_ly),
            .i_right_x (w_rx),
            .i_right_y (w_ry),
            .i_new_x   (i_data_x),
            .i_new_y   (i_data_y),
            .o_x       (w_cx[gi]),
            .o_y       (w_cy[gi]),
            .o_hit     (w_hit[gi])
        );
    end

    // Control registers
    always_comb begin
        n_s1_valid = w_accept || (r_s1_valid && !w_adv);
        n_out_valid = w_adv || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Middle stage: status, popped head and count after the request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= w_status;
            r_s1_x      <= w_pop_ok ? w_cx[0] : '0;
            r_s1_y      <= w_pop_ok ? w_cy[0] : '0;
            r_s1_count  <= n_count;
        end
    end

    // Output register: found is the OR of the registered cell matches
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_status <= r_s1_status;
            r_out_found  <= |w_hit;
            r_out_x      <= r_s1_x;
            r_out_y      <= r_s1_y;
            r_out_count  <= r_s1_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found     = r_out_found;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_count     = r_out_count;

endmodule

### rtl/core/pinq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for positional_insert_queue, attached by the bind at the end of this file.
// Depends on pinq_pkg for the status codes.
module pinq_checker import pinq_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int COMP_WIDTH = COMP_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [1:0]            o_status,
    input logic                  o_found,
    input logic [COMP_WIDTH-1:0] o_out_x,
    input logic [COMP_WIDTH-1:0] o_out_y,
    input logic [CNT_W-1:0]      o_count
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // A stalled result word holds its place
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_count) && $stable(o_status))
        else $error("stalled result changed");

    // Count never exceeds the queue depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_count <= FULL_CNT)
        else $error("count above depth");

    // A found flag comes only from a successful search, with no popped data
    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_status == ST_OK && o_out_x == '0 && o_out_y == '0)
        else $error("found with bad status or data");

    // Empty and full statuses agree with the reported count
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |-> o_count == '0 && o_out_x == '0)
        else $error("empty status with entries");

    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_count == FULL_CNT)
        else $error("full status below depth");

endmodule

bind positional_insert_queue pinq_checker #(
    .DEPTH      (DEPTH),
    .COMP_WIDTH (COMP_WIDTH),
    .CNT_W      (CNT_W)
) u_pinq_checker (.*);
